// ----- sv/rscrb_pkg.sv -----
// ----------------------------------------------------------------------------
// rscrb_pkg: shared types and constants of the ring builder
// widths, status codes, prng constants and state encoding
// ----------------------------------------------------------------------------
`default_nettype none
package rscrb_pkg;
	localparam int MaxCells = 1024;
	localparam int IdxW = $clog2(MaxCells);
	localparam int CntW = IdxW + 1;
	localparam logic [63:0] GoldenSeed = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] StarMult = 64'h2545F4914F6CDD1D;

	localparam logic [1:0] StatusOk = 2'd0;
	localparam logic [1:0] StatusNoRing = 2'd1;
	localparam logic [1:0] StatusRange = 2'd2;

	localparam logic CmdBuild = 1'b0;
	localparam logic CmdRead = 1'b1;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_FILL = 10'b0000000010,
		ST_RNG = 10'b0000000100,
		ST_MUL = 10'b0000001000,
		ST_DIV = 10'b0000010000,
		ST_SWPA = 10'b0000100000,
		ST_SWPB = 10'b0001000000,
		ST_LNKA = 10'b0010000000,
		ST_LNKB = 10'b0100000000,
		ST_DONE = 10'b1000000000
	} state_t;
endpackage
`default_nettype wire

// ----- sv/random_single_cycle_ring_builder.sv -----
// ----------------------------------------------------------------------------
// random_single_cycle_ring_builder
// builds a random single cycle over up to 1024 cells and serves successors
// ----------------------------------------------------------------------------
// usage:
//   input channel (valid/stall) carries command, seed, cell_count, cell_index
//   output channel (valid/stall) returns successor and status, one per request
//   a read request looks up the successor table; the read data is registered
//   and then loaded into the output register, and no new request is taken
//   while the read is in flight
//   a build request fills the order memory, shuffles it with one xorshift64*
//   step, a 64x64 multiply split in three 32x32 partial products and a
//   bit-serial 64-bit remainder per swap, then links the ring; input stall
//   is held high meanwhile
//   reset clears the ring valid flag, count and prng; the memories are left
//   as they are and are never read before a build writes them
//   when the receiver stalls, the output register holds its result and the
//   input stalls while a read is in flight or the output register is held
// ----------------------------------------------------------------------------
`default_nettype none
module random_single_cycle_ring_builder
	import rscrb_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic command,
	input wire logic [63:0] seed,
	input wire logic [10:0] cell_count,
	input wire logic [9:0] cell_index,
	output logic out_valid,
	input wire logic out_stall,
	output logic [9:0] successor,
	output logic [1:0] status
);
	// memories: shuffle order and successor table
	logic [IdxW-1:0] order_mem [MaxCells];
	logic [IdxW-1:0] succ_mem [MaxCells];
	logic [IdxW-1:0] ord_raddr, ord_waddr, ord_wdata, ord_rdata_q;
	logic ord_we;
	logic [IdxW-1:0] suc_raddr, suc_waddr, suc_wdata, suc_rdata_q;
	logic suc_we;

	always_ff @(posedge clk) begin
		if (ord_we) order_mem[ord_waddr] <= ord_wdata;
		ord_rdata_q <= order_mem[ord_raddr];
	end
	always_ff @(posedge clk) begin
		if (suc_we) succ_mem[suc_waddr] <= suc_wdata;
		suc_rdata_q <= succ_mem[suc_raddr];
	end

	state_t state_q;
	logic [63:0] rng_q;
	logic [CntW-1:0] count_q;
	logic ring_valid_q;
	logic [CntW-1:0] i_q; // loop index
	logic [1:0] phase_q;
	logic [63:0] prod_q;
	logic [6:0] bit_q;
	logic [CntW-1:0] rem_q;
	logic [IdxW-1:0] pick_q, held_q, first_q, prev_q;

	// read pipeline
	logic rd_s1;
	logic [1:0] rd_status_s1;
	logic out_valid_q;
	logic [9:0] succ_q;
	logic [1:0] status_q;
	logic out_free;
	logic accept;

	assign out_free = !out_valid_q || !out_stall;
	// a read in flight needs the output slot at the next edge
	assign in_stall = (state_q != ST_IDLE) || !out_free || rd_s1;
	assign accept = in_valid && !in_stall;

	// xorshift step
	logic [63:0] x1, x2, x3;
	always_comb begin
		x1 = rng_q ^ (rng_q >> 12);
		x2 = x1 ^ (x1 << 25);
		x3 = x2 ^ (x2 >> 27);
	end

	// partial product of the star multiply
	logic [31:0] pa, pb;
	logic [63:0] pp;
	always_comb begin
		pa = phase_q[0] ? rng_q[63:32] : rng_q[31:0];
		pb = phase_q[1] ? StarMult[63:32] : StarMult[31:0];
		pp = pa * pb;
	end

	// bit-serial remainder step, divisor i+1
	logic [CntW-1:0] divisor;
	logic [CntW:0] rem_sh;
	assign divisor = i_q + CntW'(1);
	assign rem_sh = {rem_q, prod_q[6'(bit_q - 7'd1)]};

	always_comb begin
		ord_we = 1'b0;
		ord_waddr = i_q[IdxW-1:0];
		ord_wdata = i_q[IdxW-1:0];
		ord_raddr = i_q[IdxW-1:0];
		suc_we = 1'b0;
		suc_waddr = prev_q;
		suc_wdata = ord_rdata_q;
		suc_raddr = cell_index;
		unique case (state_q)
			ST_FILL: ord_we = 1'b1;
			ST_SWPA: begin
				// read old order[pick] while order[i] goes into order[pick]
				ord_raddr = pick_q;
				ord_we = 1'b1;
				ord_waddr = pick_q;
				ord_wdata = held_q;
			end
			ST_SWPB: begin
				ord_we = 1'b1;
				ord_waddr = i_q[IdxW-1:0];
				ord_wdata = ord_rdata_q; // old order[pick] into order[i]
			end
			ST_LNKB: suc_we = (i_q != '0);
			ST_DONE: begin
				suc_we = 1'b1;
				suc_wdata = first_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rng_q <= '0;
			count_q <= '0;
			ring_valid_q <= 1'b0;
			rd_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rd_s1 || state_q == ST_DONE) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			rd_s1 <= accept && (command == CmdRead);
			if (rd_s1) begin
				status_q <= rd_status_s1;
				succ_q <= (rd_status_s1 == StatusOk) ? suc_rdata_q : '0;
			end else if (state_q == ST_DONE) begin
				succ_q <= '0;
				status_q <= StatusOk;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (command == CmdRead) begin
							if (!ring_valid_q) rd_status_s1 <= StatusNoRing;
							else if ({1'b0, cell_index} >= count_q)
								rd_status_s1 <= StatusRange;
							else rd_status_s1 <= StatusOk;
						end else begin
							if (cell_count == '0) count_q <= CntW'(1);
							else if (cell_count > 11'(MaxCells)) count_q <= CntW'(MaxCells);
							else count_q <= cell_count;
							rng_q <= (seed != '0) ? seed : GoldenSeed;
							i_q <= '0;
							state_q <= ST_FILL;
						end
					end
				end
				ST_FILL: begin
					if (i_q + CntW'(1) == count_q) begin
						if (i_q == '0) state_q <= ST_LNKA;
						else state_q <= ST_RNG;
					end else i_q <= i_q + CntW'(1);
				end
				ST_RNG: begin
					rng_q <= x3;
					prod_q <= '0;
					phase_q <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					unique case (phase_q)
						2'd0: prod_q <= pp;
						2'd1: prod_q[63:32] <= prod_q[63:32] + pp[31:0];
						2'd2: prod_q[63:32] <= prod_q[63:32] + pp[31:0];
						default: ;
					endcase
					phase_q <= phase_q + 2'd1;
					if (phase_q == 2'd2) begin
						state_q <= ST_DIV;
						bit_q <= 7'd64;
						rem_q <= '0;
					end
				end
				ST_DIV: begin
					if (bit_q == 7'd0) begin
						pick_q <= rem_q[IdxW-1:0];
						held_q <= ord_rdata_q; // order[i] read during div
						state_q <= ST_SWPA;
					end else begin
						rem_q <= (rem_sh >= {1'b0, divisor}) ?
							CntW'(rem_sh - {1'b0, divisor}) : rem_sh[CntW-1:0];
						bit_q <= bit_q - 7'd1;
					end
				end
				ST_SWPA: state_q <= ST_SWPB;
				ST_SWPB: begin
					i_q <= i_q - CntW'(1);
					if (i_q == CntW'(1)) state_q <= ST_LNKA;
					else state_q <= ST_RNG;
				end
				ST_LNKA: state_q <= ST_LNKB; // read order[i]
				ST_LNKB: begin
					if (i_q == '0) first_q <= ord_rdata_q;
					prev_q <= ord_rdata_q;
					if (i_q + CntW'(1) == count_q) state_q <= ST_DONE;
					else begin
						i_q <= i_q + CntW'(1);
						state_q <= ST_LNKA;
					end
				end
				ST_DONE: begin
					ring_valid_q <= 1'b1;
					if (!out_free) state_q <= ST_DONE;
					else state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign successor = succ_q;
	assign status = status_q;
endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of random_single_cycle_ring_builder
// builds rings from random seeds and sizes, reads successors back and
// compares each result with an in-bench ring predictor, under random
// request gaps and output stalls
// ----------------------------------------------------------------------------
module tb_top;
	import rscrb_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic command = CmdBuild;
	logic [63:0] seed = '0;
	logic [10:0] cell_count = '0;
	logic [9:0] cell_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [9:0] successor;
	logic [1:0] status;

	random_single_cycle_ring_builder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.seed(seed),
		.cell_count(cell_count),
		.cell_index(cell_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.successor(successor),
		.status(status)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state: a private copy of the ring
	logic [9:0] ring_next [MaxCells];
	logic [63:0] prng_state = '0;
	int unsigned ring_size = 0;
	bit ring_built = 1'b0;

	// results still owed by the block, oldest first
	logic [9:0] succ_owed [$];
	logic [1:0] status_owed [$];

	bit gaps_on = 1'b1;   // random idling on both sides
	int errors = 0;

	// one xorshift64* step of the predictor
	function automatic logic [63:0] prng_step();
		logic [63:0] x;
		x = prng_state;
		x ^= x >> 12;
		x ^= x << 25;
		x ^= x >> 27;
		prng_state = x;
		return x * StarMult;
	endfunction

	// fisher-yates shuffle from the top down, then link into one cycle
	task automatic predict_ring(input logic [63:0] s, input logic [10:0] cnt);
		int unsigned order [MaxCells];
		int unsigned n;
		int unsigned pick;
		int unsigned held;
		n = (cnt == 0) ? 1 : (cnt > MaxCells) ? MaxCells : cnt;
		for (int i = 0; i < n; i++) order[i] = i;
		prng_state = (s != 0) ? s : GoldenSeed;
		for (int i = n - 1; i > 0; i--) begin
			pick = 32'(prng_step() % (64'(i) + 64'd1));
			held = order[i];
			order[i] = order[pick];
			order[pick] = held;
		end
		for (int k = 0; k + 1 < n; k++) ring_next[order[k]] = 10'(order[k + 1]);
		ring_next[order[n - 1]] = 10'(order[0]);
		ring_size = n;
		ring_built = 1'b1;
	endtask

	// work out what the block owes for one accepted request
	task automatic predict_request(input logic cmd, input logic [63:0] s,
			input logic [10:0] cnt, input logic [9:0] idx);
		if (cmd == CmdBuild) begin
			predict_ring(s, cnt);
			succ_owed.push_back('0);
			status_owed.push_back(StatusOk);
		end else if (!ring_built) begin
			succ_owed.push_back('0);
			status_owed.push_back(StatusNoRing);
		end else if (idx >= ring_size) begin
			succ_owed.push_back('0);
			status_owed.push_back(StatusRange);
		end else begin
			succ_owed.push_back(ring_next[idx]);
			status_owed.push_back(StatusOk);
		end
	endtask

	// present one request and hold it until the block takes it
	task automatic send_request(input logic cmd, input logic [63:0] s,
			input logic [10:0] cnt, input logic [9:0] idx);
		// occasional idle gap before the request
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		command <= cmd;
		seed <= s;
		cell_count <= cnt;
		cell_index <= idx;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_request(cmd, s, cnt, idx);
	endtask

	task automatic send_build(input logic [63:0] s, input logic [10:0] cnt);
		send_request(CmdBuild, s, cnt, 10'($urandom));
	endtask

	task automatic send_read(input logic [9:0] idx);
		send_request(CmdRead, {$urandom, $urandom}, 11'($urandom), idx);
	endtask

	// read-before-build, zero and oversized counts, single cell, extremes
	task automatic test_directed();
		send_read(10'd0);
		send_read(10'd1023);
		send_build(64'd0, 11'd0);          // zero count acts as one cell
		send_read(10'd0);                  // single cell points to itself
		send_read(10'd1);
		send_build(64'd0, 11'd1);          // zero seed uses the golden constant
		send_read(10'd0);
		send_build('1, 11'd2);
		send_read(10'd0);
		send_read(10'd1);
		send_read(10'd2);
		send_build(64'h8000_0000_0000_0001, 11'd1024);
		send_read(10'd0);
		send_read(10'd1023);
		send_read(10'd512);
		send_build(64'h0123_4567_89ab_cdef, 11'd2047);   // saturates to full size
		send_read(10'd1023);
		send_read(10'd1);
		send_build(64'hffff_ffff_0000_0000, 11'd1025);
		send_read(10'd1022);
		send_build(64'd1, 11'd3);
		send_read(10'd2);
		send_read(10'd3);
	endtask

	// mostly small rings from random seeds, each followed by random reads
	task automatic test_random_rings(input int unsigned requests);
		int unsigned sent;
		int unsigned n;
		logic [10:0] cnt;
		sent = 0;
		while (sent < requests) begin
			if ($urandom_range(0, 59) == 0) cnt = 11'($urandom_range(0, 2047));
			else cnt = 11'($urandom_range(1, 24));
			send_build({$urandom, $urandom}, cnt);
			n = (cnt == 0) ? 1 : (cnt > MaxCells) ? MaxCells : cnt;
			sent++;
			repeat ($urandom_range(4, 14)) begin
				if ($urandom_range(0, 9) < 7) send_read(10'($urandom_range(0, n - 1)));
				else send_read(10'($urandom));
				sent++;
			end
			// the last stretch runs with no gaps or stalls
			if (sent > requests - 200) gaps_on = 1'b0;
		end
	endtask

	// receiver: random stall bursts, checks every accepted result in order
	int stall_left = 0;
	always @(posedge clk) begin
		if (out_valid && !out_stall && arst_n) begin
			if (succ_owed.size() == 0) begin
				$error("unexpected result successor=%0d status=%0d", successor, status);
				errors++;
			end else begin
				if (successor !== succ_owed[0]) begin
					$error("successor: expected %0d actual %0d", succ_owed[0], successor);
					errors++;
				end
				if (status !== status_owed[0]) begin
					$error("status: expected %0d actual %0d", status_owed[0], status);
					errors++;
				end
				void'(succ_owed.pop_front());
				void'(status_owed.pop_front());
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (gaps_on && $urandom_range(0, 6) == 0) begin
			stall_left = $urandom_range(0, 2);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_rings(1525);
		in_valid <= 1'b0;
		while (succ_owed.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && succ_owed.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// timeout: far beyond the slowest expected run
	initial begin
		#(8 * 4_000_000);
		$display("FAIL");
		$finish;
	end
endmodule
